/* rtl/lav_pkg.sv */
package lav_pkg;

    localparam int CW   = 32;
    localparam int FB   = 16;
    localparam int VW   = CW + 3;
    localparam int MW   = VW;
    localparam int NB   = 30;
    localparam int UW   = FB + 2;
    localparam int RW   = VW - FB;
    localparam int TW   = RW + CW + 2;
    localparam int SW   = TW - FB + 1;
    localparam int LW   = NB + 1;
    localparam int SQP  = 2 * NB;
    localparam int SUMW = 2 * NB + 2;
    localparam int RTW  = SUMW + 1;
    localparam int DW   = NB + FB + 1;

    typedef enum logic [2:0] {
        N_IDLE,
        N_SHIFT,
        N_SQ,
        N_ROOT,
        N_LOAD,
        N_DIV
    } t_norm_state;

    typedef enum logic [3:0] {
        C_IDLE,
        C_NF,
        C_NU,
        C_X1,
        C_NS,
        C_X2,
        C_ROWS,
        C_TR,
        C_EMIT
    } t_core_state;

    typedef struct packed {
        logic [2:0][CW-1:0] eye;
        logic [2:0][CW:0]   fw;
        logic [2:0][CW-1:0] up;
    } t_cam;

    typedef struct packed {
        logic valid;
        t_cam cam;
    } t_cam_q;

    typedef struct packed {
        logic               done;
        logic               ok;
        logic [2:0][UW-1:0] u;
    } t_norm_res;

    typedef struct packed {
        logic [1:0]    idx;
        logic [CW-1:0] c0;
        logic [CW-1:0] c1;
        logic [CW-1:0] c2;
        logic [CW-1:0] c3;
        logic          degen;
        logic          last;
    } t_row;

    function automatic logic [CW-1:0] sat_cw(input logic [SW-1:0] x);
        logic fits;
        fits = (&x[SW-1:CW-1]) | ~(|x[SW-1:CW-1]);
        if (fits) begin
            return x[CW-1:0];
        end else if (x[SW-1]) begin
            return {1'b1, {(CW-1){1'b0}}};
        end else begin
            return {1'b0, {(CW-1){1'b1}}};
        end
    endfunction

    localparam logic [CW-1:0] ONE_SAT = sat_cw(SW'(1) << FB);

endpackage

/* rtl/lav_front.sv */
module lav_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_push,
    output logic                           o_full,
    input  logic [2:0][lav_pkg::CW-1:0]    i_eye,
    input  logic [2:0][lav_pkg::CW-1:0]    i_target,
    input  logic [2:0][lav_pkg::CW-1:0]    i_up,
    output lav_pkg::t_cam_q                o_head,
    input  logic                           i_take
);
    import lav_pkg::*;

    t_cam       r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    t_cam       w_cam;
    logic       w_push;
    logic       w_pop;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_cam.eye[i] = i_eye[i];
            w_cam.up[i]  = i_up[i];
            w_cam.fw[i]  = {i_target[i][CW-1], i_target[i]} - {i_eye[i][CW-1], i_eye[i]};
        end
    end

    assign o_full       = (r_cnt == 2'd2);
    assign w_push       = i_push && !o_full;
    assign w_pop        = i_take && (r_cnt != 2'd0);
    assign o_head.valid = (r_cnt != 2'd0);
    assign o_head.cam   = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cam;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

endmodule

/* rtl/lav_norm.sv */
module lav_norm (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [2:0][lav_pkg::VW-1:0] i_vec,
    output lav_pkg::t_norm_res          o_res
);
    import lav_pkg::*;

    t_norm_state        r_state;
    t_norm_state        n_state;
    logic [2:0][MW-1:0] r_m;
    logic [2:0]         r_neg;
    logic [4:0]         r_cnt;
    logic [1:0]         r_ci;
    logic [SQP-1:0]     r_prod;
    logic [SUMW-1:0]    r_sum;
    logic [RTW-1:0]     r_n;
    logic [RTW-1:0]     r_r;
    logic [RTW-1:0]     r_bit;
    logic [DW-1:0]      r_num;
    logic [FB:0]        r_q;
    logic               r_done;
    logic               r_ok;
    logic [2:0][UW-1:0] r_u;

    logic [2:0][MW-1:0] w_mag;
    logic               w_allz;
    logic [MW-1:0]      w_mx;
    logic               w_big;
    logic               w_small;
    logic [RTW-1:0]     w_rb;
    logic               w_ge;
    logic [LW-1:0]      w_len;
    logic [DW-1:0]      w_d;
    logic               w_dge;
    logic [FB:0]        w_qn;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_mag[i] = i_vec[i][VW-1] ? (~i_vec[i] + MW'(1)) : i_vec[i];
        end
        w_allz  = (w_mag == '0);
        w_mx    = (r_m[0] > r_m[1]) ? r_m[0] : r_m[1];
        w_mx    = (r_m[2] > w_mx) ? r_m[2] : w_mx;
        w_big   = |w_mx[MW-1:NB];
        w_small = ~(|w_mx[MW-1:NB-1]);
        w_rb    = r_r + r_bit;
        w_ge    = (r_n >= w_rb);
        w_len   = r_r[LW-1:0];
        w_d     = DW'(w_len) << r_cnt;
        w_dge   = (r_num >= w_d);
        w_qn    = r_q | ({{FB{1'b0}}, w_dge} << r_cnt);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            N_IDLE: begin
                if (i_start && !w_allz) begin
                    n_state = N_SHIFT;
                end
            end
            N_SHIFT: begin
                if (!w_big && !w_small) begin
                    n_state = N_SQ;
                end
            end
            N_SQ: begin
                if (r_cnt == 5'd3) begin
                    n_state = N_ROOT;
                end
            end
            N_ROOT: begin
                if (r_cnt == 5'd31) begin
                    n_state = N_LOAD;
                end
            end
            N_LOAD: begin
                n_state = N_DIV;
            end
            N_DIV: begin
                if (r_cnt == 5'd0) begin
                    n_state = (r_ci == 2'd2) ? N_IDLE : N_LOAD;
                end
            end
            default: begin
                n_state = N_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= N_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= (r_state == N_IDLE && i_start && w_allz)
                   || (r_state == N_DIV && r_cnt == 5'd0 && r_ci == 2'd2);
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            N_IDLE: begin
                if (i_start) begin
                    r_m <= w_mag;
                    for (int i = 0; i < 3; i++) begin
                        r_neg[i] <= i_vec[i][VW-1];
                    end
                    if (w_allz) begin
                        r_ok <= 1'b0;
                        r_u  <= '0;
                    end
                end
            end
            N_SHIFT: begin
                if (w_big) begin
                    for (int i = 0; i < 3; i++) begin
                        r_m[i] <= r_m[i] >> 1;
                    end
                end else if (w_small) begin
                    for (int i = 0; i < 3; i++) begin
                        r_m[i] <= r_m[i] << 1;
                    end
                end else begin
                    r_cnt <= 5'd0;
                    r_sum <= '0;
                end
            end
            N_SQ: begin
                if (r_cnt != 5'd3) begin
                    r_prod <= SQP'(r_m[r_cnt[1:0]][NB-1:0]) * SQP'(r_m[r_cnt[1:0]][NB-1:0]);
                end
                if (r_cnt != 5'd0) begin
                    r_sum <= r_sum + SUMW'(r_prod);
                end
                if (r_cnt == 5'd3) begin
                    r_n   <= RTW'(r_sum) + RTW'(r_prod);
                    r_r   <= '0;
                    r_bit <= RTW'(1) << (RTW - 1);
                    r_cnt <= 5'd0;
                end else begin
                    r_cnt <= r_cnt + 5'd1;
                end
            end
            N_ROOT: begin
                if (w_ge) begin
                    r_n <= r_n - w_rb;
                    r_r <= (r_r >> 1) + r_bit;
                end else begin
                    r_r <= r_r >> 1;
                end
                r_bit <= r_bit >> 2;
                r_cnt <= r_cnt + 5'd1;
                r_ci  <= 2'd0;
            end
            N_LOAD: begin
                r_num <= (DW'(r_m[r_ci][NB-1:0]) << FB) + DW'(w_len >> 1);
                r_q   <= '0;
                r_cnt <= 5'(FB);
            end
            N_DIV: begin
                if (w_dge) begin
                    r_num <= r_num - w_d;
                end
                r_q   <= w_qn;
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd0) begin
                    r_u[r_ci] <= r_neg[r_ci] ? (UW'(0) - UW'(w_qn)) : UW'(w_qn);
                    r_ci      <= r_ci + 2'd1;
                    r_ok      <= 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_res.done = r_done;
    assign o_res.ok   = r_ok;
    assign o_res.u    = r_u;

endmodule

/* rtl/lav_core.sv */
module lav_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  lav_pkg::t_cam_q i_head,
    output logic            o_take,
    output lav_pkg::t_row   o_row,
    output logic            o_empty,
    input  logic            i_pop
);
    import lav_pkg::*;

    t_core_state             r_state;
    t_core_state             n_state;
    t_cam                    r_cam;
    logic                    r_ok;
    logic                    r_kick;
    logic [2:0]              r_cnt;
    logic                    r_xv;
    logic [1:0]              r_xc;
    logic                    r_xs;
    logic signed [2*UW-1:0]  r_xp;
    logic [2:0][UW-1:0]      r_f;
    logic [2:0][UW-1:0]      r_un;
    logic [2:0][UW-1:0]      r_s;
    logic [2:0][VW-1:0]      r_acc;
    logic [2:0][2:0][RW-1:0] r_row;
    logic [1:0]              r_k;
    logic [1:0]              r_i;
    logic [1:0]              r_pk;
    logic                    r_pv;
    logic signed [RW+CW-1:0] r_tp;
    logic [2:0][TW-1:0]      r_t;
    logic [1:0]              r_e;
    t_row                    r_oq [4];
    logic [1:0]              r_wp;
    logic [1:0]              r_rp;
    logic [2:0]              r_oc;

    t_norm_res               w_nr;
    logic [2:0][VW-1:0]      w_vec;
    logic [1:0]              w_ia;
    logic [1:0]              w_ib;
    logic signed [UW-1:0]    w_ma;
    logic signed [UW-1:0]    w_mb;
    logic [2:0][VW-1:0]      w_r1;
    logic [2:0][RW-1:0]      w_fx;
    logic [1:0]              w_ti;
    logic [TW-1:0]           w_tr;
    logic [SW-1:0]           w_fl;
    t_row                    w_row;
    logic                    w_push;
    logic                    w_pop;

    lav_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_kick),
        .i_vec   (w_vec),
        .o_res   (w_nr)
    );

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            case (r_state)
                C_NF:    w_vec[i] = {{(VW-CW-1){r_cam.fw[i][CW]}}, r_cam.fw[i]};
                C_NU:    w_vec[i] = {{(VW-CW){r_cam.up[i][CW-1]}}, r_cam.up[i]};
                default: w_vec[i] = r_acc[i];
            endcase
            w_r1[i] = r_acc[i] + (VW'(1) << (FB - 1));
            w_fx[i] = {{(RW-UW){r_f[i][UW-1]}}, r_f[i]};
        end
    end

    always_comb begin
        case (r_cnt)
            3'd0:    begin w_ia = 2'd1; w_ib = 2'd2; end
            3'd1:    begin w_ia = 2'd2; w_ib = 2'd1; end
            3'd2:    begin w_ia = 2'd2; w_ib = 2'd0; end
            3'd3:    begin w_ia = 2'd0; w_ib = 2'd2; end
            3'd4:    begin w_ia = 2'd0; w_ib = 2'd1; end
            3'd5:    begin w_ia = 2'd1; w_ib = 2'd0; end
            default: begin w_ia = 2'd0; w_ib = 2'd0; end
        endcase
        w_ma = (r_state == C_X1) ? $signed(r_f[w_ia]) : $signed(r_s[w_ia]);
        w_mb = (r_state == C_X1) ? $signed(r_un[w_ib]) : $signed(r_f[w_ib]);
    end

    always_comb begin
        w_ti = (r_e == 2'd3) ? 2'd0 : r_e;
        w_tr = r_t[w_ti] + (TW'(1) << (FB - 1));
        w_fl = {w_tr[TW-1], w_tr[TW-1:FB]};
        w_row.idx   = r_e;
        w_row.degen = !r_ok;
        w_row.last  = (r_e == 2'd3);
        if (r_e == 2'd3) begin
            w_row.c0 = '0;
            w_row.c1 = '0;
            w_row.c2 = '0;
            w_row.c3 = ONE_SAT;
        end else begin
            w_row.c0 = sat_cw(SW'($signed(r_row[w_ti][0])));
            w_row.c1 = sat_cw(SW'($signed(r_row[w_ti][1])));
            w_row.c2 = sat_cw(SW'($signed(r_row[w_ti][2])));
            w_row.c3 = sat_cw(SW'(0) - w_fl);
        end
    end

    assign o_take  = (r_state == C_IDLE) && i_head.valid;
    assign w_push  = (r_state == C_EMIT) && (r_oc != 3'd4);
    assign w_pop   = i_pop && (r_oc != 3'd0);
    assign o_empty = (r_oc == 3'd0);
    assign o_row   = r_oq[r_rp];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            C_IDLE: begin
                if (i_head.valid) begin
                    n_state = C_NF;
                end
            end
            C_NF: begin
                if (w_nr.done) begin
                    n_state = C_NU;
                end
            end
            C_NU: begin
                if (w_nr.done) begin
                    n_state = C_X1;
                end
            end
            C_X1: begin
                if (r_cnt == 3'd6) begin
                    n_state = C_NS;
                end
            end
            C_NS: begin
                if (w_nr.done) begin
                    n_state = C_X2;
                end
            end
            C_X2: begin
                if (r_cnt == 3'd6) begin
                    n_state = C_ROWS;
                end
            end
            C_ROWS: begin
                n_state = C_TR;
            end
            C_TR: begin
                if (r_k == 2'd3 && !r_pv) begin
                    n_state = C_EMIT;
                end
            end
            C_EMIT: begin
                if (w_push && r_e == 2'd3) begin
                    n_state = C_IDLE;
                end
            end
            default: begin
                n_state = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_kick  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_kick  <= (r_state == C_IDLE && i_head.valid)
                    || (r_state == C_NF && w_nr.done)
                    || (r_state == C_X1 && r_cnt == 3'd6);
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state) inside
            C_IDLE: begin
                if (i_head.valid) begin
                    r_cam <= i_head.cam;
                    r_ok  <= 1'b1;
                end
            end
            C_NF: begin
                if (w_nr.done) begin
                    r_f  <= w_nr.u;
                    r_ok <= r_ok & w_nr.ok;
                end
            end
            C_NU, C_NS: begin
                if (w_nr.done) begin
                    if (r_state == C_NU) begin
                        r_un <= w_nr.u;
                    end else begin
                        r_s <= w_nr.u;
                    end
                    r_ok  <= r_ok & w_nr.ok;
                    r_cnt <= 3'd0;
                    r_xv  <= 1'b0;
                    r_acc <= '0;
                end
            end
            C_X1, C_X2: begin
                if (r_cnt != 3'd6) begin
                    r_xp  <= w_ma * w_mb;
                    r_xc  <= r_cnt[2:1];
                    r_xs  <= r_cnt[0];
                    r_xv  <= 1'b1;
                    r_cnt <= r_cnt + 3'd1;
                end
                if (r_xv) begin
                    r_acc[r_xc] <= r_xs ? (r_acc[r_xc] - r_xp[VW-1:0])
                                        : (r_acc[r_xc] + r_xp[VW-1:0]);
                end
            end
            C_ROWS: begin
                for (int i = 0; i < 3; i++) begin
                    r_row[0][i] <= r_ok ? RW'($signed(r_s[i])) : '0;
                    r_row[1][i] <= r_ok ? w_r1[i][VW-1:FB] : '0;
                    r_row[2][i] <= r_ok ? (RW'(0) - w_fx[i]) : '0;
                end
                r_k  <= 2'd0;
                r_i  <= 2'd0;
                r_pv <= 1'b0;
                r_t  <= '0;
                r_e  <= 2'd0;
            end
            C_TR: begin
                if (r_k != 2'd3) begin
                    r_tp <= $signed(r_row[r_k][r_i]) * $signed(r_cam.eye[r_i]);
                    r_pk <= r_k;
                    r_pv <= 1'b1;
                    if (r_i == 2'd2) begin
                        r_i <= 2'd0;
                        r_k <= r_k + 2'd1;
                    end else begin
                        r_i <= r_i + 2'd1;
                    end
                end else begin
                    r_pv <= 1'b0;
                end
                if (r_pv) begin
                    r_t[r_pk] <= r_t[r_pk] + TW'(r_tp);
                end
            end
            C_EMIT: begin
                if (w_push) begin
                    r_e <= r_e + 2'd1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_oq[r_wp] <= w_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 2'd0;
            r_rp <= 2'd0;
            r_oc <= 3'd0;
        end else begin
            if (w_push) begin
                r_wp <= r_wp + 2'd1;
            end
            if (w_pop) begin
                r_rp <= r_rp + 2'd1;
            end
            r_oc <= r_oc + {2'b0, w_push} - {2'b0, w_pop};
        end
    end

endmodule

/* rtl/look_at_view_matrix.sv */
// Look-at view matrix in signed Q16.16. Each camera item (eye, target, up) pushed in
// gives four row items, row 0 (side) to row 3 (0 0 0 1), with the eye translation in
// column 3. A two-entry input queue takes new cameras while the back end works on one
// camera at a time; a four-entry output queue holds rows until popped. Per camera, the
// back end runs one shared normalize unit three times (a one-bit-per-cycle scaling shift,
// a 32-step square root and a 17-step divide per component), plus the cross products,
// dot products and row output. A zero vector skips its normalize, so a degenerate camera
// finishes sooner, and the back end waits while the output queue is full.
// degenerate is set on all four rows when forward, up or side has zero length.
module look_at_view_matrix (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic signed [lav_pkg::CW-1:0] i_eye_x,
    input  logic signed [lav_pkg::CW-1:0] i_eye_y,
    input  logic signed [lav_pkg::CW-1:0] i_eye_z,
    input  logic signed [lav_pkg::CW-1:0] i_target_x,
    input  logic signed [lav_pkg::CW-1:0] i_target_y,
    input  logic signed [lav_pkg::CW-1:0] i_target_z,
    input  logic signed [lav_pkg::CW-1:0] i_up_x,
    input  logic signed [lav_pkg::CW-1:0] i_up_y,
    input  logic signed [lav_pkg::CW-1:0] i_up_z,
    output logic                        empty,
    input  logic                        pop,
    output logic [1:0]                  o_row_index,
    output logic signed [lav_pkg::CW-1:0] o_col_zero,
    output logic signed [lav_pkg::CW-1:0] o_col_one,
    output logic signed [lav_pkg::CW-1:0] o_col_two,
    output logic signed [lav_pkg::CW-1:0] o_col_three,
    output logic                        o_degenerate,
    output logic                        o_last_row
);
    import lav_pkg::*;

    logic [2:0][CW-1:0] w_eye;
    logic [2:0][CW-1:0] w_target;
    logic [2:0][CW-1:0] w_up;
    t_cam_q             w_head;
    logic               w_take;
    t_row               w_row;

    assign w_eye    = {i_eye_z, i_eye_y, i_eye_x};
    assign w_target = {i_target_z, i_target_y, i_target_x};
    assign w_up     = {i_up_z, i_up_y, i_up_x};

    lav_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .o_full   (full),
        .i_eye    (w_eye),
        .i_target (w_target),
        .i_up     (w_up),
        .o_head   (w_head),
        .i_take   (w_take)
    );

    lav_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .o_take  (w_take),
        .o_row   (w_row),
        .o_empty (empty),
        .i_pop   (pop)
    );

    assign o_row_index  = w_row.idx;
    assign o_col_zero   = w_row.c0;
    assign o_col_one    = w_row.c1;
    assign o_col_two    = w_row.c2;
    assign o_col_three  = w_row.c3;
    assign o_degenerate = w_row.degen;
    assign o_last_row   = w_row.last;

    a_last_is_row3: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_last_row) |-> (o_row_index == 2'd3))
        else $error("last row flag on a row other than row 3");

    a_row3_const: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_row_index == 2'd3) |->
        (o_col_zero == '0 && o_col_one == '0 && o_col_two == '0 && o_col_three == ONE_SAT))
        else $error("row 3 is not 0 0 0 1");

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_degenerate && o_row_index != 2'd3) |->
        (o_col_zero == '0 && o_col_one == '0 && o_col_two == '0 && o_col_three == '0))
        else $error("degenerate camera gave a nonzero rotation row");

endmodule

/* bench/look_at_view_matrix_tb.sv */
module look_at_view_matrix_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lav_pkg::*;

    typedef longint vec3_t [3];

    typedef struct {
        logic signed [CW-1:0] eye [3];
        logic signed [CW-1:0] tgt [3];
        logic signed [CW-1:0] up [3];
    } camera_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic push = 1'b0;
    logic pop = 1'b0;
    logic full;
    logic empty;
    logic signed [CW-1:0] eye_x = '0, eye_y = '0, eye_z = '0;
    logic signed [CW-1:0] tgt_x = '0, tgt_y = '0, tgt_z = '0;
    logic signed [CW-1:0] up_x = '0, up_y = '0, up_z = '0;
    logic [1:0] o_row_index;
    logic signed [CW-1:0] o_col_zero, o_col_one, o_col_two, o_col_three;
    logic o_degenerate, o_last_row;

    t_row expected_rows [$];
    int errors = 0;
    int rows_checked = 0;
    int cameras_sent = 0;
    int degenerate_cameras = 0;
    int burst_left = 0;
    int hold_left = 0;
    bit hold_req = 0;
    int rx_cycle = 0;
    int rx_mode = 0;

    look_at_view_matrix u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_eye_x     (eye_x),
        .i_eye_y     (eye_y),
        .i_eye_z     (eye_z),
        .i_target_x  (tgt_x),
        .i_target_y  (tgt_y),
        .i_target_z  (tgt_z),
        .i_up_x      (up_x),
        .i_up_y      (up_y),
        .i_up_z      (up_z),
        .empty       (empty),
        .pop         (pop),
        .o_row_index (o_row_index),
        .o_col_zero  (o_col_zero),
        .o_col_one   (o_col_one),
        .o_col_two   (o_col_two),
        .o_col_three (o_col_three),
        .o_degenerate(o_degenerate),
        .o_last_row  (o_last_row)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [CW-1:0] saturate(input longint x);
        longint hi, lo;
        hi = (longint'(1) <<< (CW - 1)) - 1;
        lo = -hi - 1;
        if (x > hi) x = hi;
        if (x < lo) x = lo;
        return x[CW-1:0];
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic bit unit_vec(input vec3_t v, output vec3_t u);
        longint unsigned m [3];
        longint unsigned mx, sum, len, q;
        mx = 0;
        sum = 0;
        for (int i = 0; i < 3; i++) begin
            m[i] = (v[i] < 0) ? longint'(-v[i]) : v[i];
            if (m[i] > mx) mx = m[i];
        end
        if (mx == 0) begin
            u[0] = 0; u[1] = 0; u[2] = 0;
            return 1'b0;
        end
        while (mx >= (64'd1 << 30)) begin
            mx = mx >> 1;
            for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
        end
        while (mx < (64'd1 << 29)) begin
            mx = mx << 1;
            for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
        end
        for (int i = 0; i < 3; i++) sum += m[i] * m[i];
        len = int_sqrt(sum);
        for (int i = 0; i < 3; i++) begin
            q = ((m[i] << FB) + (len >> 1)) / len;
            u[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
        end
        return 1'b1;
    endfunction

    function automatic void cross3(input vec3_t a, input vec3_t b, output vec3_t r);
        r[0] = a[1] * b[2] - a[2] * b[1];
        r[1] = a[2] * b[0] - a[0] * b[2];
        r[2] = a[0] * b[1] - a[1] * b[0];
    endfunction

    function automatic void predict_view_rows(input camera_t c);
        vec3_t eye, fw, upv, f, un, sr, s, ur;
        longint rows [3][3];
        longint half, a, b, t, eh, el;
        bit ok_f, ok_u, ok_s, ok;
        t_row r;
        half = longint'(1) <<< (FB - 1);
        for (int i = 0; i < 3; i++) begin
            eye[i] = longint'(c.eye[i]);
            fw[i] = longint'(c.tgt[i]) - eye[i];
            upv[i] = longint'(c.up[i]);
        end
        ok_f = unit_vec(fw, f);
        ok_u = unit_vec(upv, un);
        cross3(f, un, sr);
        ok_s = unit_vec(sr, s);
        ok = ok_f && ok_u && ok_s;
        cross3(s, f, ur);
        if (!ok) degenerate_cameras++;
        for (int i = 0; i < 3; i++) begin
            rows[0][i] = ok ? s[i] : 0;
            rows[1][i] = ok ? ((ur[i] + half) >>> FB) : 0;
            rows[2][i] = ok ? -f[i] : 0;
        end
        for (int k = 0; k < 3; k++) begin
            a = 0;
            b = 0;
            for (int i = 0; i < 3; i++) begin
                eh = eye[i] >>> FB;
                el = eye[i] - (eh <<< FB);
                a += rows[k][i] * eh;
                b += rows[k][i] * el;
            end
            t = a + ((b + half) >>> FB);
            r.idx = k[1:0];
            r.c0 = saturate(rows[k][0]);
            r.c1 = saturate(rows[k][1]);
            r.c2 = saturate(rows[k][2]);
            r.c3 = saturate(-t);
            r.degen = !ok;
            r.last = 1'b0;
            expected_rows.push_back(r);
        end
        r.idx = 2'd3;
        r.c0 = '0;
        r.c1 = '0;
        r.c2 = '0;
        r.c3 = saturate(longint'(1) <<< FB);
        r.degen = !ok;
        r.last = 1'b1;
        expected_rows.push_back(r);
    endfunction

    task automatic send_camera(input camera_t c);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = $urandom_range(1, 10);
            if (gap > 0) begin
                push <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        eye_x <= c.eye[0]; eye_y <= c.eye[1]; eye_z <= c.eye[2];
        tgt_x <= c.tgt[0]; tgt_y <= c.tgt[1]; tgt_z <= c.tgt[2];
        up_x <= c.up[0]; up_y <= c.up[1]; up_z <= c.up[2];
        push <= 1'b1;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        predict_view_rows(c);
        cameras_sent++;
        burst_left--;
    endtask

    function automatic logic signed [CW-1:0] rand_coord();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return $signed($urandom_range(0, 65535)) - 32768;
            2, 3: return $signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000;
            4: return $signed($urandom_range(0, 32'h0fff_ffff)) - 32'sh0800_0000;
            5: return {1'b1, 31'($urandom())};
            default: return $urandom();
        endcase
    endfunction

    function automatic camera_t random_camera();
        camera_t c;
        int sel;
        for (int i = 0; i < 3; i++) begin
            c.eye[i] = rand_coord();
            c.tgt[i] = rand_coord();
            c.up[i] = rand_coord();
        end
        sel = $urandom_range(0, 19);
        if (sel == 0) begin
            c.tgt = c.eye;
        end else if (sel == 1) begin
            c.up[0] = '0; c.up[1] = '0; c.up[2] = '0;
        end else if (sel == 2) begin
            for (int i = 0; i < 3; i++) c.tgt[i] = c.eye[i] + 32'(2 * (i + 1));
            for (int i = 0; i < 3; i++) c.up[i] = 32'(4 * (i + 1));
        end
        return c;
    endfunction

    function automatic camera_t make_camera(input int ex, ey, ez, tx, ty, tz, ux, uy, uz);
        camera_t c;
        c.eye[0] = ex; c.eye[1] = ey; c.eye[2] = ez;
        c.tgt[0] = tx; c.tgt[1] = ty; c.tgt[2] = tz;
        c.up[0] = ux; c.up[1] = uy; c.up[2] = uz;
        return c;
    endfunction

    task automatic test_directed();
        int mx, mn, one;
        mx = 32'sh7fff_ffff;
        mn = 32'sh8000_0000;
        one = 32'sh0001_0000;
        send_camera(make_camera(0, 0, one * 5, 0, 0, 0, 0, one, 0));
        send_camera(make_camera(one, 2 * one, 3 * one, -one, 0, 0, 0, 0, one));
        send_camera(make_camera(one, one, one, one, one, one, 0, one, 0));
        send_camera(make_camera(0, 0, 0, one, 0, 0, 0, 0, 0));
        send_camera(make_camera(0, 0, 0, one, 0, 0, 5 * one, 0, 0));
        send_camera(make_camera(0, 0, 0, 3, 0, 0, -7, 0, 0));
        send_camera(make_camera(mn, mn, mn, mx, mx, mx, 0, one, 0));
        send_camera(make_camera(mx, mx, mx, mn, mn, mn, mx, mn, mx));
        send_camera(make_camera(mx, 0, mn, 0, mx, 0, mn, mn, mn));
        send_camera(make_camera(mn, mx, 0, mn, mn, 0, 1, 0, 0));
        send_camera(make_camera(-1, -1, -1, 1, 1, 1, 0, -1, 0));
        send_camera(make_camera(mx, mx, mx, mx - one, mx, mx, 0, 1, 0));
        send_camera(make_camera(mn, mn, mn, mn, mn + 1, mn, 0, 0, mx));
        send_camera(make_camera(32'sh1234_5678, -32'sh0765_4321, 32'sh0abc_def0,
                                -32'sh0123_4567, 32'sh0fed_cba9, 0, 3, 1, -2));
        send_camera(make_camera(0, 0, 0, one, 1, 0, one, 0, 0));
        send_camera(make_camera(-one, -one, -one, 0, 0, 0, 1, 1, 1));
        send_camera(make_camera(mx, mn, mx, mx, mn, mx, 0, one, 0));
        send_camera(make_camera(0, 0, 0, 0, 0, -one, -one, 0, 0));
    endtask

    task automatic test_random(input int count);
        for (int n = 0; n < count; n++) begin
            if (n == count / 3) hold_req = 1'b1;
            send_camera(random_camera());
        end
    endtask

    task automatic test_drain_pause();
        push <= 1'b0;
        burst_left = 0;
        wait (expected_rows.size() == 0);
        @(posedge i_clk);
        for (int n = 0; n < 6; n++) send_camera(random_camera());
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            if (expected_rows.size() == 0) begin
                $error("row item with no expectation: row_index %0d", o_row_index);
                errors++;
            end else begin
                t_row e;
                e = expected_rows.pop_front();
                rows_checked++;
                if (o_row_index !== e.idx) begin
                    $error("row_index: expected %0d, got %0d", e.idx, o_row_index);
                    errors++;
                end
                if (o_col_zero !== e.c0) begin
                    $error("col_zero: expected %0d, got %0d", $signed(e.c0), o_col_zero);
                    errors++;
                end
                if (o_col_one !== e.c1) begin
                    $error("col_one: expected %0d, got %0d", $signed(e.c1), o_col_one);
                    errors++;
                end
                if (o_col_two !== e.c2) begin
                    $error("col_two: expected %0d, got %0d", $signed(e.c2), o_col_two);
                    errors++;
                end
                if (o_col_three !== e.c3) begin
                    $error("col_three: expected %0d, got %0d", $signed(e.c3), o_col_three);
                    errors++;
                end
                if (o_degenerate !== e.degen) begin
                    $error("degenerate: expected %0d, got %0d", e.degen, o_degenerate);
                    errors++;
                end
                if (o_last_row !== e.last) begin
                    $error("last_row: expected %0d, got %0d", e.last, o_last_row);
                    errors++;
                end
            end
        end
        rx_cycle++;
        if (rx_cycle % 97 == 0) rx_mode = $urandom_range(0, 3);
        if (hold_req) begin
            hold_req = 1'b0;
            hold_left = 3000;
        end
        if (hold_left > 0) begin
            hold_left--;
            pop <= 1'b0;
        end else begin
            case (rx_mode)
                0: pop <= 1'b1;
                1: pop <= $urandom_range(0, 1);
                2: pop <= ($urandom_range(0, 5) == 0);
                default: pop <= (rx_cycle % 8) < 3;
            endcase
        end
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(100);
        test_drain_pause();
        test_random(114);
        push <= 1'b0;
        wait (expected_rows.size() == 0);
        repeat (500) @(posedge i_clk);
        $display("cameras sent: %0d (%0d degenerate), row items checked: %0d",
                 cameras_sent, degenerate_cameras, rows_checked);
        if (errors == 0 && expected_rows.size() == 0) begin
            $display("look_at_view_matrix test passed");
        end else begin
            $display("look_at_view_matrix test failed");
        end
        $finish;
    end

    initial begin
        #40ms;
        $display("look_at_view_matrix test failed");
        $finish;
    end

endmodule

/* look_at_view_matrix.f */
rtl/lav_pkg.sv
rtl/lav_front.sv
rtl/lav_norm.sv
rtl/lav_core.sv
rtl/look_at_view_matrix.sv
bench/look_at_view_matrix_tb.sv
